FILE: sv/sha1s_pkg.sv
`timescale 1ns / 1ps
package sha1s_pkg;

    localparam int unsigned QDepth = 16;
    localparam int unsigned QAw    = 4;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word data;
        logic  msg_end;
    } t_qword;

    localparam logic [4:0][31:0] IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    function automatic t_word round_k(input logic [6:0] t);
        t_word k;
        if (t < 7'd20) begin
            k = 32'h5A827999;
        end else if (t < 7'd40) begin
            k = 32'h6ED9EBA1;
        end else if (t < 7'd60) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

endpackage

FILE: sv/sha1_stream_hash_unit.sv
`timescale 1ns / 1ps
// SHA-1 hash of a byte stream. Each input word on i_valid/o_ready carries one
// message byte (when i_has_byte is set) and an end-of-message flag i_is_last.
// A word with neither flag does nothing. A front end packs bytes into 32-bit
// words, appends the pad byte, zero fill and the 64-bit bit length after the
// last word, and pushes them into a 16-word queue. The compression core pops
// 16 words per block, runs 80 rounds at one per cycle and adds the result
// into the chaining value, while the front end fills the queue with up to 16
// further words. The round loop sets the sustained input rate.
// After the last word the front end pushes the padding words, waiting while
// the queue is full. The five digest words, h0 first, then appear on
// o_valid/i_ready with o_word_index and o_last_word, once the core has run
// the rounds of the final block and added them into the chaining value.
// While the receiver stalls, the core holds the digest and the front end
// keeps taking bytes until the queue is full.
// After the fifth word the chaining value returns to its initial value.
// Reset clears all counters and loads the initial chaining value.
module sha1_stream_hash_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    logic              w_push;
    logic              w_pop;
    logic              w_full;
    logic              w_empty;
    sha1s_pkg::t_qword w_wdata;
    sha1s_pkg::t_qword w_rdata;

    sha1s_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_msg_byte (i_msg_byte),
        .i_has_byte (i_has_byte),
        .i_is_last  (i_is_last),
        .o_push     (w_push),
        .o_wdata    (w_wdata),
        .i_full     (w_full)
    );

    sha1s_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wdata),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_rdata),
        .o_empty (w_empty)
    );

    sha1s_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .o_pop         (w_pop),
        .i_rdata       (w_rdata),
        .i_empty       (w_empty),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

FILE: sv/sha1s_queue.sv
`timescale 1ns / 1ps
module sha1s_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sha1s_pkg::t_qword i_wdata,
    output logic              o_full,
    input  logic              i_pop,
    output sha1s_pkg::t_qword o_rdata,
    output logic              o_empty
);

    sha1s_pkg::t_qword              r_mem [sha1s_pkg::QDepth];
    logic [sha1s_pkg::QAw-1:0]      r_wp;
    logic [sha1s_pkg::QAw-1:0]      r_rp;
    logic [sha1s_pkg::QAw:0]        r_cnt;

    assign o_full  = (r_cnt == (sha1s_pkg::QAw+1)'(sha1s_pkg::QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/sha1s_front.sv
`timescale 1ns / 1ps
module sha1s_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_msg_byte,
    input  logic              i_has_byte,
    input  logic              i_is_last,
    output logic              o_push,
    output sha1s_pkg::t_qword o_wdata,
    input  logic              i_full
);

    typedef enum logic {
        S_DATA,
        S_PAD
    } t_state;

    t_state      r_state;
    logic [60:0] r_cnt;
    logic [31:0] r_acc;
    logic [3:0]  r_pw;
    logic        r_first;
    logic        r_extra;

    logic        n_take;
    logic [60:0] n_cnt;
    logic [31:0] n_acc;
    logic [31:0] n_padw;
    logic [63:0] n_bits;

    assign o_ready = (r_state == S_DATA) && !i_full;
    assign n_take  = i_valid && o_ready;
    assign n_cnt   = r_cnt + {60'd0, i_has_byte};
    assign n_bits  = {r_cnt, 3'b000};

    always_comb begin
        n_acc = r_acc;
        case (r_cnt[1:0])
            2'd0:    n_acc[31:24] = i_msg_byte;
            2'd1:    n_acc[23:16] = i_msg_byte;
            2'd2:    n_acc[15:8]  = i_msg_byte;
            2'd3:    n_acc[7:0]   = i_msg_byte;
            default: n_acc        = r_acc;
        endcase
    end

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    n_padw = 32'h8000_0000;
            2'd1:    n_padw = {r_acc[31:24], 24'h80_0000};
            2'd2:    n_padw = {r_acc[31:16], 16'h8000};
            2'd3:    n_padw = {r_acc[31:8], 8'h80};
            default: n_padw = 32'h8000_0000;
        endcase
    end

    always_comb begin
        o_push          = 1'b0;
        o_wdata.data    = n_acc;
        o_wdata.msg_end = 1'b0;
        if (r_state == S_DATA) begin
            o_push = n_take && i_has_byte && (r_cnt[1:0] == 2'd3);
        end else begin
            o_push = !i_full;
            if (r_first) begin
                o_wdata.data = n_padw;
            end else if (!r_extra && (r_pw == 4'd14)) begin
                o_wdata.data = n_bits[63:32];
            end else if (!r_extra && (r_pw == 4'd15)) begin
                o_wdata.data = n_bits[31:0];
            end else begin
                o_wdata.data = '0;
            end
            o_wdata.msg_end = !r_extra && (r_pw == 4'd15);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_DATA;
            r_cnt   <= '0;
            r_pw    <= '0;
            r_first <= 1'b0;
            r_extra <= 1'b0;
        end else begin
            case (r_state)
                S_DATA: begin
                    if (n_take) begin
                        if (i_has_byte) begin
                            r_acc <= n_acc;
                        end
                        r_cnt <= n_cnt;
                        if (i_is_last) begin
                            r_state <= S_PAD;
                            r_pw    <= n_cnt[5:2];
                            r_first <= 1'b1;
                            r_extra <= (n_cnt[5:2] >= 4'd14);
                        end
                    end
                end
                S_PAD: begin
                    if (o_push) begin
                        r_first <= 1'b0;
                        r_pw    <= r_pw + 1'b1;
                        if (r_pw == 4'd15) begin
                            if (r_extra) begin
                                r_extra <= 1'b0;
                            end else begin
                                r_state <= S_DATA;
                                r_cnt   <= '0;
                            end
                        end
                    end
                end
                default: r_state <= S_DATA;
            endcase
        end
    end

endmodule

FILE: sv/sha1s_core.sv
`timescale 1ns / 1ps
module sha1s_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output logic              o_pop,
    input  sha1s_pkg::t_qword i_rdata,
    input  logic              i_empty,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_digest_word,
    output logic [2:0]        o_word_index,
    output logic              o_last_word
);

    typedef enum logic [1:0] {
        B_LOAD,
        B_ROUND,
        B_ADD,
        B_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_h [5];
    logic [31:0] r_w [16];
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_c;
    logic [31:0] r_d;
    logic [31:0] r_e;
    logic [6:0]  r_t;
    logic [3:0]  r_ld;
    logic        r_final;
    logic [2:0]  r_idx;

    logic [31:0] n_f;
    logic [31:0] n_tmp;
    logic [31:0] n_wx;
    logic [31:0] n_wnew;

    assign o_pop         = (r_state == B_LOAD) && !i_empty;
    assign o_valid       = (r_state == B_OUT);
    assign o_digest_word = r_h[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd4);

    assign n_wx   = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign n_wnew = {n_wx[30:0], n_wx[31]};

    always_comb begin
        if (r_t < 7'd20) begin
            n_f = (r_b & r_c) | (~r_b & r_d);
        end else if ((r_t >= 7'd40) && (r_t < 7'd60)) begin
            n_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
        end else begin
            n_f = r_b ^ r_c ^ r_d;
        end
    end

    assign n_tmp = {r_a[26:0], r_a[31:27]} + n_f + r_e + sha1s_pkg::round_k(r_t) + r_w[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_LOAD;
            r_t     <= '0;
            r_ld    <= '0;
            r_final <= 1'b0;
            r_idx   <= '0;
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= sha1s_pkg::IV[i];
            end
        end else begin
            case (r_state)
                B_LOAD: begin
                    if (o_pop) begin
                        for (int i = 0; i < 15; i++) begin
                            r_w[i] <= r_w[i+1];
                        end
                        r_w[15] <= i_rdata.data;
                        r_ld    <= r_ld + 1'b1;
                        if (r_ld == 4'd15) begin
                            r_final <= i_rdata.msg_end;
                            r_state <= B_ROUND;
                            r_t     <= '0;
                            r_a     <= r_h[0];
                            r_b     <= r_h[1];
                            r_c     <= r_h[2];
                            r_d     <= r_h[3];
                            r_e     <= r_h[4];
                        end
                    end
                end
                B_ROUND: begin
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= n_wnew;
                    r_a     <= n_tmp;
                    r_b     <= r_a;
                    r_c     <= {r_b[1:0], r_b[31:2]};
                    r_d     <= r_c;
                    r_e     <= r_d;
                    r_t     <= r_t + 1'b1;
                    if (r_t == 7'd79) begin
                        r_state <= B_ADD;
                    end
                end
                B_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    r_idx  <= '0;
                    r_state <= r_final ? B_OUT : B_LOAD;
                end
                B_OUT: begin
                    if (i_ready) begin
                        if (r_idx == 3'd4) begin
                            for (int i = 0; i < 5; i++) begin
                                r_h[i] <= sha1s_pkg::IV[i];
                            end
                            r_idx   <= '0;
                            r_state <= B_LOAD;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= B_LOAD;
            endcase
        end
    end

endmodule

FILE: tb/sv/tb_sha1_stream_hash_unit.sv
`timescale 1ns / 1ps
module tb_sha1_stream_hash_unit;

    localparam int unsigned DigestWords = 5;
    localparam int unsigned BlockBytes  = 64;
    localparam int unsigned LenOffset   = 56;
    localparam logic [7:0]  PadByte     = 8'h80;
    localparam int unsigned ItemGoal    = 400;
    localparam int unsigned SettleCycles = 250;

    localparam logic [31:0] StartH [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] RoundK [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };
    localparam int unsigned EdgeLens [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       is_last;
    } t_stream_word;

    typedef struct {
        sha1s_pkg::t_word value;
        logic [2:0]       index;
        logic             last;
    } t_digest_word;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_msg_byte  = 8'h00;
    logic        i_has_byte  = 1'b0;
    logic        i_is_last   = 1'b0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    t_stream_word pending_words[$];
    t_digest_word digest_q[$];

    logic [31:0] chain_h [5];
    logic [7:0]  block_bytes [BlockBytes];
    logic [60:0] byte_total;

    int errors     = 0;
    int real_items = 0;
    int send_gap   = 0;
    int recv_stall = 0;
    int calm_left  = 0;

    sha1_stream_hash_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_msg_byte    (i_msg_byte),
        .i_has_byte    (i_has_byte),
        .i_is_last     (i_is_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void absorb_block();
        logic [31:0] sched [16];
        logic [31:0] a, b, c, d, e, f, w, sum;
        for (int t = 0; t < 16; t++) begin
            sched[t] = {block_bytes[4*t], block_bytes[4*t+1],
                        block_bytes[4*t+2], block_bytes[4*t+3]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
                w = rotl(sched[(t-3)%16] ^ sched[(t-8)%16] ^ sched[(t-14)%16]
                         ^ sched[t%16], 1);
                sched[t%16] = w;
            end else begin
                w = sched[t];
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
            end else if (t < 40) begin
                f = b ^ c ^ d;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
            end else begin
                f = b ^ c ^ d;
            end
            sum = rotl(a, 5) + f + e + RoundK[t/20] + w;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = sum;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void hash_word(input t_stream_word sw);
        int unsigned pos;
        logic [63:0] bit_len;
        if (sw.has_byte) begin
            block_bytes[byte_total[5:0]] = sw.data;
            byte_total++;
            if (byte_total[5:0] == 6'd0) begin
                absorb_block();
            end
        end
        if (!sw.is_last) begin
            return;
        end
        pos = byte_total[5:0];
        block_bytes[pos] = PadByte;
        pos++;
        if (pos > LenOffset) begin
            while (pos < BlockBytes) begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            absorb_block();
            pos = 0;
        end
        while (pos < LenOffset) begin
            block_bytes[pos] = 8'h00;
            pos++;
        end
        bit_len = {byte_total, 3'b000};
        for (int i = 0; i < 8; i++) begin
            block_bytes[LenOffset+i] = bit_len[63-8*i -: 8];
        end
        absorb_block();
        for (int i = 0; i < DigestWords; i++) begin
            digest_q.push_back('{chain_h[i], 3'(i), (i == DigestWords - 1)});
        end
        chain_h = StartH;
        byte_total = '0;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0) begin
            calm_left = $urandom_range(40, 150);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_word(input logic [7:0] d, input logic h, input logic l);
        pending_words.push_back('{d, h, l});
        if (h || l) begin
            real_items++;
        end
    endfunction

    // Empty words without the last flag are sprinkled in as noise.
    function automatic void queue_message(input int unsigned len, input bit empty_end);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 24) == 0) begin
                queue_word(8'($urandom), 1'b0, 1'b0);
            end
            queue_word(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
        end
        if (len == 0 || empty_end) begin
            queue_word(8'($urandom), 1'b0, 1'b1);
        end
    endfunction

    function automatic int unsigned pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return EdgeLens[$urandom_range(0, 8)];
        if (r < 25) return 0;
        return $urandom_range(1, 40);
    endfunction

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : driver
        t_stream_word nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                hash_word('{i_msg_byte, i_has_byte, i_is_last});
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0 || pending_words.size() == 0) begin
                    i_valid <= 1'b0;
                    if (send_gap > 0) begin
                        send_gap--;
                    end
                end else begin
                    nxt = pending_words.pop_front();
                    i_valid    <= 1'b1;
                    i_msg_byte <= nxt.data;
                    i_has_byte <= nxt.has_byte;
                    i_is_last  <= nxt.is_last;
                    send_gap = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_digest_word want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (digest_q.size() == 0) begin
                    $error("digest_word: unexpected word %h at index %0d",
                           o_digest_word, o_word_index);
                    errors++;
                end else begin
                    want = digest_q.pop_front();
                    if (o_digest_word !== want.value) begin
                        $error("digest_word: expected %h, got %h", want.value, o_digest_word);
                        errors++;
                    end
                    if (o_word_index !== want.index) begin
                        $error("word_index: expected %0d, got %0d", want.index, o_word_index);
                        errors++;
                    end
                    if (o_last_word !== want.last) begin
                        $error("last_word: expected %0b, got %0b", want.last, o_last_word);
                        errors++;
                    end
                end
            end
            if (recv_stall > 0) begin
                i_ready <= 1'b0;
                recv_stall--;
            end else begin
                i_ready <= 1'b1;
                recv_stall = pick_gap();
            end
        end
    end

    initial begin
        #(1_000_000);
        $display("tb_sha1_stream_hash_unit: done, errors");
        $finish;
    end

    initial begin
        chain_h = StartH;
        byte_total = '0;

        // Directed words: empty message, "abc", ignored words, extreme bytes
        // and both ways of ending a message.
        queue_word(8'h00, 1'b0, 1'b1);
        queue_word(8'h61, 1'b1, 1'b0);
        queue_word(8'h62, 1'b1, 1'b0);
        queue_word(8'h63, 1'b1, 1'b1);
        queue_word(8'hFF, 1'b0, 1'b0);
        queue_word(8'h00, 1'b1, 1'b1);
        queue_word(8'hFF, 1'b1, 1'b0);
        queue_word(8'h5A, 1'b0, 1'b0);
        queue_word(8'hA5, 1'b1, 1'b0);
        queue_word(8'hFF, 1'b0, 1'b1);
        queue_word(8'hFF, 1'b1, 1'b1);
        queue_message(55, 1'b0);

        while (real_items < ItemGoal) begin
            queue_message(pick_len(), $urandom_range(0, 3) == 0);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_valid || digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);

        if (digest_q.size() != 0) begin
            $error("digest_word: %0d expected words never arrived", digest_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("tb_sha1_stream_hash_unit: done, clean");
        end else begin
            $display("tb_sha1_stream_hash_unit: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/sha1s_pkg.sv
sv/sha1s_queue.sv
sv/sha1s_front.sv
sv/sha1s_core.sv
sv/sha1_stream_hash_unit.sv
tb/sv/tb_sha1_stream_hash_unit.sv
